>>> sv/thdc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thermometer display controller package
// Shared item codes, register indexes, segment constants and the small
// conversion functions used by the datapath.
// ----------------------------------------------------------------------------
package thdc_pkg;

    // Item kinds carried on the input channel
    typedef enum logic [1:0] {
        KIND_SAMPLE = 2'd0,
        KIND_BUTTON = 2'd1,
        KIND_SCAN   = 2'd2
    } kind_t;

    // Configuration register indexes
    localparam logic REG_COLD_LIMIT = 1'b0;
    localparam logic REG_WARM_LIMIT = 1'b1;

    localparam int LIMIT_W = 7;
    localparam int TEMP_W  = 7;

    localparam logic [LIMIT_W-1:0] COLD_LIMIT_RESET = 7'd20;
    localparam logic [LIMIT_W-1:0] WARM_LIMIT_RESET = 7'd30;

    // Segment patterns, bit0 is segment a
    localparam logic [6:0] SEG_DEGREE = 7'h63;
    localparam logic [6:0] SEG_C      = 7'h39;
    localparam logic [6:0] SEG_F      = 7'h71;

    // Band light codes
    localparam logic [2:0] BAND_COLD = 3'b001;
    localparam logic [2:0] BAND_MILD = 3'b010;
    localparam logic [2:0] BAND_HOT  = 3'b100;

    // Digit drive for the leftmost position
    localparam logic [3:0] DIGIT_LEFT = 4'b1000;

    // Fahrenheit: floor((18*T + 325) / 10) folded with the 1639/2^14
    // reciprocal into one constant multiply, exact for T up to 99
    localparam logic [21:0] F_MUL  = 22'd29502;
    localparam logic [21:0] F_OFFS = 22'd532675;
    localparam int          F_SHIFT = 14;

    // Decimal digit to segment pattern
    function automatic logic [6:0] seg_of_digit(input logic [3:0] digit);
        logic [6:0] seg;
        unique case (digit)
            4'd0:    seg = 7'h3F;
            4'd1:    seg = 7'h06;
            4'd2:    seg = 7'h5B;
            4'd3:    seg = 7'h4F;
            4'd4:    seg = 7'h66;
            4'd5:    seg = 7'h6D;
            4'd6:    seg = 7'h7D;
            4'd7:    seg = 7'h07;
            4'd8:    seg = 7'h7F;
            4'd9:    seg = 7'h6F;
            default: seg = 7'h00;
        endcase
        return seg;
    endfunction

    // Tens and ones digits of a value up to 255, hundreds dropped
    typedef struct packed {
        logic [3:0] tens;
        logic [3:0] ones;
    } digits_t;

    function automatic digits_t low_digits(input logic [7:0] value);
        logic [6:0] rest;
        logic [3:0] tens;
        logic [6:0] tens_x10;
        digits_t    res;
        // strip hundreds by compare and subtract
        if (value >= 8'd200)
            rest = 7'(value - 8'd200);
        else if (value >= 8'd100)
            rest = 7'(value - 8'd100);
        else
            rest = value[6:0];
        // tens by a ladder of independent compares
        tens = 4'd0;
        for (int k = 1; k <= 9; k++) begin
            if (rest >= 7'(10 * k))
                tens = 4'(k);
        end
        tens_x10 = 7'({tens, 3'b000}) + 7'({tens, 1'b0});
        res.tens = tens;
        res.ones = 4'(rest - tens_x10);
        return res;
    endfunction

    // Result of the sample conversion, core to top level
    typedef struct packed {
        logic [2:0] band;
        digits_t    digits;
    } sample_res_t;

endpackage

>>> sv/thermometer_display_controller_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thermometer display controller
// Converts samples to band lights and display digits, toggles the unit on
// button items and scans four display positions on tick items.
// A result goes through the input register, then the result register, to the output.
// One item per cycle unless the result stalls, set by the input and result registers.
// Reset clears unit, digits, scan position, lights and drive; limits go to 20/30.
// ----------------------------------------------------------------------------
module thermometer_display_controller_top
    import thdc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // configuration
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [LIMIT_W-1:0] cfg_data,
    // input channel
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         kind,
    input  logic [7:0]         adc_sample,
    // result channel
    output logic               out_valid,
    input  logic               out_ready,
    output logic [6:0]         segment_pattern,
    output logic [3:0]         digit_enable,
    output logic [2:0]         band_lights,
    output logic               unit_is_fahrenheit
);

    logic [LIMIT_W-1:0] cold_limit_reg;
    logic [LIMIT_W-1:0] warm_limit_reg;

    logic               s1_valid_reg;
    logic [1:0]         s1_kind_reg;
    logic [TEMP_W-1:0]  s1_temp_reg;
    logic [14:0]        temp_product;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic               slot_free;
    logic               s1_fire;

    logic               mode_reg;
    logic [3:0]         tens_reg;
    logic [3:0]         ones_reg;
    logic [1:0]         scan_pos_reg;
    logic [2:0]         band_reg;
    logic [6:0]         pattern_reg;
    logic [3:0]         enable_reg;
    logic [6:0]         pattern_next;

    sample_res_t        conv;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cold_limit_reg <= COLD_LIMIT_RESET;
            warm_limit_reg <= WARM_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_COLD_LIMIT: cold_limit_reg <= cfg_data;
                REG_WARM_LIMIT: warm_limit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // handshake: stage advances when the result slot is empty or draining
    assign slot_free = !out_valid_reg || out_ready;
    assign s1_fire   = s1_valid_reg && slot_free;
    assign in_ready  = !s1_valid_reg || slot_free;

    // Celsius value 100*sample/256 taken before the input register
    assign temp_product = 15'(adc_sample) * 15'd100;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_kind_reg <= kind;
            s1_temp_reg <= temp_product[14:8];
        end
    end

    thdc_convert u_convert (
        .temp_c     (s1_temp_reg),
        .fahrenheit (mode_reg),
        .cold_limit (cold_limit_reg),
        .warm_limit (warm_limit_reg),
        .res        (conv)
    );

    // pattern for the position being scanned
    always_comb
    begin
        unique case (scan_pos_reg)
            2'd0:    pattern_next = seg_of_digit(tens_reg);
            2'd1:    pattern_next = seg_of_digit(ones_reg);
            2'd2:    pattern_next = SEG_DEGREE;
            default: pattern_next = mode_reg ? SEG_F : SEG_C;
        endcase
    end

    // display state; its registers also form the result payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= 1'b0;
            tens_reg     <= 4'd0;
            ones_reg     <= 4'd0;
            scan_pos_reg <= 2'd0;
            band_reg     <= 3'd0;
            pattern_reg  <= 7'd0;
            enable_reg   <= 4'd0;
        end
        else if (s1_fire)
        begin
            unique case (s1_kind_reg)
                KIND_SAMPLE:
                begin
                    band_reg <= conv.band;
                    tens_reg <= conv.digits.tens;
                    ones_reg <= conv.digits.ones;
                end
                KIND_BUTTON:
                begin
                    mode_reg <= !mode_reg;
                end
                KIND_SCAN:
                begin
                    pattern_reg  <= pattern_next;
                    enable_reg   <= DIGIT_LEFT >> scan_pos_reg;
                    scan_pos_reg <= scan_pos_reg + 2'd1;
                end
                default: ;  // unused kind leaves state alone
            endcase
        end
    end

    // result valid
    always_comb
    begin
        if (s1_fire)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    assign out_valid          = out_valid_reg;
    assign segment_pattern    = pattern_reg;
    assign digit_enable       = enable_reg;
    assign band_lights        = band_reg;
    assign unit_is_fahrenheit = mode_reg;

endmodule

>>> sv/thdc_convert.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sample conversion
// Picks the band light from the Celsius value and works out the shown
// tens and ones digits in the selected unit.
// ----------------------------------------------------------------------------
module thdc_convert
    import thdc_pkg::*;
(
    input  logic [TEMP_W-1:0]  temp_c,
    input  logic               fahrenheit,
    input  logic [LIMIT_W-1:0] cold_limit,
    input  logic [LIMIT_W-1:0] warm_limit,
    output sample_res_t        res
);

    logic [21:0] f_scaled;
    logic [7:0]  shown_value;
    logic [2:0]  band;

    // band choice, cold takes priority over mild
    always_comb
    begin
        priority if (temp_c < cold_limit)
            band = BAND_COLD;
        else if (temp_c < warm_limit)
            band = BAND_MILD;
        else
            band = BAND_HOT;
    end

    // unit conversion: T*1.8 + 32, rounded half up
    assign f_scaled    = 22'(temp_c) * F_MUL + F_OFFS;
    assign shown_value = fahrenheit ? f_scaled[F_SHIFT +: 8] : {1'b0, temp_c};

    assign res = {band, low_digits(shown_value)};

endmodule

>>> sv/thdc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thermometer display controller checker
// Port-level checks on the display drive, band lights and result transfer.
// ----------------------------------------------------------------------------
module thdc_checker
    import thdc_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [6:0] segment_pattern,
    input logic [3:0] digit_enable,
    input logic [2:0] band_lights,
    input logic       unit_is_fahrenheit
);

    // at most one digit driven
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(digit_enable))
        else $error("more than one digit driven");

    // at most one band light
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(band_lights))
        else $error("more than one band light");

    // degree position always carries the degree sign
    assert property (@(posedge clk) disable iff (!rst_n)
        (digit_enable == 4'b0010) |-> (segment_pattern == SEG_DEGREE))
        else $error("degree position shows wrong pattern");

    // unit position carries C or F
    assert property (@(posedge clk) disable iff (!rst_n)
        (digit_enable == 4'b0001) |->
            (segment_pattern == SEG_C || segment_pattern == SEG_F))
        else $error("unit position shows wrong pattern");

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(segment_pattern) && $stable(digit_enable)
             && $stable(band_lights) && $stable(unit_is_fahrenheit)))
        else $error("stalled result changed");

endmodule

bind thermometer_display_controller_top thdc_checker u_thdc_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .segment_pattern    (segment_pattern),
    .digit_enable       (digit_enable),
    .band_lights        (band_lights),
    .unit_is_fahrenheit (unit_is_fahrenheit)
);
